[hw/rtl/macp_pkg.sv]
// Shared types, constants and the hex digit decoder for the address text parser.
// No dependencies.
package macp_pkg;

    // text layout: six two-digit bytes and five delimiters
    localparam int unsigned TEXT_LEN = 17;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned ADDR_W   = 48;
    localparam int unsigned NIB_W    = 4;

    localparam logic [POS_W-1:0] POS_FULL = POS_W'(TEXT_LEN);

    // character slot within one byte group (position mod 3)
    localparam logic [1:0] PHASE_HI  = 2'd0;
    localparam logic [1:0] PHASE_LO  = 2'd1;
    localparam logic [1:0] PHASE_SEP = 2'd2;

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // parse state carried from one item to the next
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [1:0]        phase;
        logic [ADDR_W-1:0] acc;
        logic              err;
    } t_parse_state;

    // decoded digit: valid flag and nibble value
    typedef struct packed {
        logic             ok;
        logic [NIB_W-1:0] nib;
    } t_hex_digit;

    function automatic t_hex_digit hex_decode(input logic [7:0] ch);
        t_hex_digit d;
        logic [7:0] diff;
        d    = '0;
        diff = '0;
        if (ch inside {[CH_0:CH_9]}) begin
            diff  = ch - CH_0;
            d.ok  = 1'b1;
            d.nib = diff[NIB_W-1:0];
        end else if (ch inside {[CH_LA:CH_LF]}) begin
            diff  = ch - CH_LA + 8'd10;
            d.ok  = 1'b1;
            d.nib = diff[NIB_W-1:0];
        end else if (ch inside {[CH_UA:CH_UF]}) begin
            diff  = ch - CH_UA + 8'd10;
            d.ok  = 1'b1;
            d.nib = diff[NIB_W-1:0];
        end
        return d;
    endfunction

endpackage

[hw/rtl/mac_address_text_parser.sv]
// Top level of the address text parser: input register, parse state, result register.
// Depends on macp_pkg and macp_step.

// Parses "xx:xx:xx:xx:xx:xx" text one character per item; ':' and '-' may be
// mixed and hex digits may be either case. A zero character ends the string
// and yields one item: the 48-bit address (first byte in bits 47:40) and a
// status, 0 for a valid address and 1 for malformed text (address then 0).
// Every other character yields nothing. An item is taken every cycle while no
// terminator waits: each item is held in the input register, where the
// combinational character step runs, and a terminator's result then goes to
// the result register; only a terminator can wait on a full result register.
module mac_address_text_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_char_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [macp_pkg::ADDR_W-1:0] o_mac_address,
    output logic                        o_parse_status
);

    logic                        r_in_valid;
    logic [7:0]                  r_char;
    macp_pkg::t_parse_state      r_state;
    macp_pkg::t_parse_state      n_state;
    logic                        r_out_valid;
    logic [macp_pkg::ADDR_W-1:0] r_mac;
    logic                        r_status;

    logic                        term;
    logic [macp_pkg::ADDR_W-1:0] step_mac;
    logic                        step_status;
    logic                        out_free;
    logic                        advance;

    macp_step u_step (
        .i_char         (r_char),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_term         (term),
        .o_mac_address  (step_mac),
        .o_parse_status (step_status)
    );

    // the held item moves on unless it is a terminator facing a full result slot
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (!term || out_free);
    assign o_ready  = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char_in;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && term) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && term) begin
            r_mac    <= step_mac;
            r_status <= step_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mac_address  = r_mac;
    assign o_parse_status = r_status;

endmodule

[hw/rtl/macp_step.sv]
// Next-state and result logic for one character of the address text.
// Depends on macp_pkg.
module macp_step (
    input  logic [7:0]                   i_char,
    input  macp_pkg::t_parse_state       i_state,
    output macp_pkg::t_parse_state       o_state,
    output logic                         o_term,
    output logic [macp_pkg::ADDR_W-1:0]  o_mac_address,
    output logic                         o_parse_status
);

    macp_pkg::t_hex_digit digit;
    logic                 good;

    assign digit = macp_pkg::hex_decode(i_char);
    assign o_term = (i_char == macp_pkg::CH_NUL);

    // result on the terminator
    assign good           = !i_state.err && (i_state.pos == macp_pkg::POS_FULL);
    assign o_mac_address  = good ? i_state.acc : '0;
    assign o_parse_status = good ? macp_pkg::STATUS_OK : macp_pkg::STATUS_BAD;

    // state update
    always_comb begin
        o_state = i_state;
        if (o_term) begin
            o_state = '0;
        end else if (i_state.err) begin
            o_state = i_state;
        end else if (i_state.pos == macp_pkg::POS_FULL) begin
            // extra characters after a complete address
            o_state.err = 1'b1;
        end else if (i_state.phase == macp_pkg::PHASE_SEP) begin
            if (i_char == macp_pkg::CH_COLON || i_char == macp_pkg::CH_DASH) begin
                o_state.pos   = i_state.pos + 1'b1;
                o_state.phase = macp_pkg::PHASE_HI;
            end else begin
                o_state.err = 1'b1;
            end
        end else if (digit.ok) begin
            o_state.acc   = {i_state.acc[macp_pkg::ADDR_W-macp_pkg::NIB_W-1:0], digit.nib};
            o_state.pos   = i_state.pos + 1'b1;
            o_state.phase = (i_state.phase == macp_pkg::PHASE_HI) ? macp_pkg::PHASE_LO
                                                                  : macp_pkg::PHASE_SEP;
        end else begin
            o_state.err = 1'b1;
        end
    end

endmodule
